// ===== hw/rtl/smf_tep_pkg.sv =====
`default_nettype none
package smf_tep_pkg;

   // sizing
   localparam int MAX_VLQ_BYTES = 4;
   localparam int CAPTURE_BYTES = 4;
   localparam int VLQ_CNT_W     = $clog2(MAX_VLQ_BYTES + 1);
   localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES + 1);
   localparam int CAP_SEL_W     = (CAPTURE_BYTES > 1) ? $clog2(CAPTURE_BYTES) : 1;
   localparam int VAL_W         = 28;
   localparam int TEMPO_W       = 24;
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_W     = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W     = $clog2(RSP_DEPTH + 1);

   // parser phases
   localparam logic [2:0] PH_DELTA   = 3'd0;
   localparam logic [2:0] PH_STATUS  = 3'd1;
   localparam logic [2:0] PH_DATA    = 3'd2;
   localparam logic [2:0] PH_MTYPE   = 3'd3;
   localparam logic [2:0] PH_LEN     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_SKIP    = 3'd6;

   // outcome codes
   localparam logic [1:0] OUTCOME_EVENT = 2'd0;
   localparam logic [1:0] OUTCOME_END   = 2'd1;
   localparam logic [1:0] OUTCOME_ERROR = 2'd2;

   // event kinds
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_SYSEX   = 2'd1;
   localparam logic [1:0] KIND_META    = 2'd2;
   localparam logic [1:0] KIND_SYSCONT = 2'd3;

   // status bytes and meta types
   localparam logic [7:0] ST_SYSEX      = 8'hF0;
   localparam logic [7:0] ST_SYSCONT    = 8'hF7;
   localparam logic [7:0] ST_META       = 8'hFF;
   localparam logic [7:0] META_CHAN_PFX = 8'h20;
   localparam logic [7:0] META_EOT      = 8'h2F;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] META_TIMESIG  = 8'h58;

   // timing after reset
   localparam logic [TEMPO_W-1:0] TEMPO_RESET  = 24'd500000;
   localparam logic [7:0]         NUM_RESET    = 8'd4;
   localparam logic [7:0]         DENEXP_RESET = 8'd2;
   localparam logic [7:0]         CLOCKS_RESET = 8'd24;
   localparam logic [7:0]         T32_RESET    = 8'd8;

   typedef struct packed {
      logic [1:0]         outcome;
      logic [1:0]         event_kind;
      logic [VAL_W-1:0]   delta_ticks;
      logic [7:0]         status_value;
      logic [7:0]         channel_number;
      logic [7:0]         data_first;
      logic [7:0]         data_second;
      logic [VAL_W-1:0]   payload_length;
      logic [TEMPO_W-1:0] tempo_usec;
      logic [7:0]         ts_numerator;
      logic [7:0]         sig_denominator_exp;
      logic [15:0]        sig_clock_info;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/smf_track_event_parser_core.sv =====
`default_nettype none
// channel   | direction | payload                                | handshake
// req       | in        | data_byte, chunk_end                   | req_valid / req_stall
// rsp       | out       | outcome .. sig_clock_info (12 fields)  | rsp_valid / rsp_stall
//
// one track byte is taken per cycle; its parse and the result build are one
// combinational pass from the parser state registers into a 4-word result queue
// a byte gives zero, one or two result words; req_stall rises while fewer than
// two queue slots are free, so the rate is 1 byte per cycle as long as rsp keeps up
// reset (synchronous, active high) starts a fresh track, timing back to defaults
// rsp words leave the queue in order, one per cycle, held while rsp_stall is high
module smf_track_event_parser_core
   import smf_tep_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_chunk_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_outcome,
   output logic [1:0]              rsp_event_kind,
   output logic [VAL_W-1:0]        rsp_delta_ticks,
   output logic [7:0]              rsp_status_value,
   output logic [7:0]              rsp_channel_number,
   output logic [7:0]              rsp_data_first,
   output logic [7:0]              rsp_data_second,
   output logic [VAL_W-1:0]        rsp_payload_length,
   output logic [TEMPO_W-1:0]      rsp_tempo_usec,
   output logic [7:0]              rsp_ts_numerator,
   output logic [7:0]              rsp_sig_denominator_exp,
   output logic [15:0]             rsp_sig_clock_info
);

   // parser state
   logic [2:0]           phase_ff, phase_in;
   logic [VAL_W-1:0]     delta_ff, delta_in;
   logic [VLQ_CNT_W-1:0] vlq_cnt_ff, vlq_cnt_in;
   logic [7:0]           running_ff, running_in;
   logic [7:0]           prefix_ff, prefix_in;
   logic [7:0]           cur_status_ff, cur_status_in;
   logic [7:0]           meta_ff, meta_in;
   logic [VAL_W-1:0]     remain_ff, remain_in;
   logic [VAL_W-1:0]     total_ff, total_in;
   logic [CAP_IDX_W-1:0] cap_idx_ff, cap_idx_in;
   logic [7:0]           cap_ff [CAPTURE_BYTES];
   logic [7:0]           cap_in [CAPTURE_BYTES];

   // timing state, kept across tracks
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic [7:0]           num_ff, num_in;
   logic [7:0]           denexp_ff, denexp_in;
   logic [7:0]           clocks_ff, clocks_in;
   logic [7:0]           t32_ff, t32_in;

   // result queue
   result_type           rsp_q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic                 req_accept;
   logic                 rsp_pop;
   logic [1:0]           push_n;
   result_type           word0, word1, end_word;

   logic                 err, done, eot, cap_en;
   logic [7:0]           sb;
   logic [VLQ_CNT_W-1:0] vlq_inc;
   logic [VAL_W-1:0]     vlq_delta, vlq_len;
   logic [1:0]           kind;
   logic [7:0]           ev_status, ev_chan;

   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = rsp_valid && !rsp_stall;
   // room for two words must be there before a byte is taken
   assign req_stall  = (rsp_cnt_ff > RSP_CNT_W'(RSP_DEPTH - 2));

   assign vlq_inc   = vlq_cnt_ff + VLQ_CNT_W'(1);
   assign vlq_delta = {delta_ff[VAL_W-8:0], req_data_byte[6:0]};
   assign vlq_len   = {remain_ff[VAL_W-8:0], req_data_byte[6:0]};
   assign sb        = req_data_byte[7] ? req_data_byte : running_ff;

   always_comb begin
      phase_in      = phase_ff;
      delta_in      = delta_ff;
      vlq_cnt_in    = vlq_cnt_ff;
      running_in    = running_ff;
      prefix_in     = prefix_ff;
      cur_status_in = cur_status_ff;
      meta_in       = meta_ff;
      remain_in     = remain_ff;
      total_in      = total_ff;
      cap_idx_in    = cap_idx_ff;
      cap_in        = cap_ff;
      tempo_in      = tempo_ff;
      num_in        = num_ff;
      denexp_in     = denexp_ff;
      clocks_in     = clocks_ff;
      t32_in        = t32_ff;
      err           = 1'b0;
      done          = 1'b0;
      eot           = 1'b0;
      cap_en        = 1'b0;
      kind          = KIND_CHANNEL;
      ev_status     = 8'd0;
      ev_chan       = 8'd0;
      push_n        = 2'd0;
      word0         = '0;
      word1         = '0;
      end_word      = '0;

      case (phase_ff)
         PH_DELTA: begin
            delta_in = vlq_delta;
            if (!req_data_byte[7]) begin
               phase_in   = PH_STATUS;
               vlq_cnt_in = '0;
            end else begin
               vlq_cnt_in = vlq_inc;
               if (vlq_inc >= VLQ_CNT_W'(MAX_VLQ_BYTES)) begin
                  err = 1'b1;
               end
            end
         end
         PH_STATUS: begin
            for (int i = 0; i < CAPTURE_BYTES; i++) begin
               cap_in[i] = 8'd0;
            end
            meta_in = 8'd0;
            if (!req_data_byte[7] && running_ff == 8'd0) begin
               // data byte with no running status held
               err = 1'b1;
            end else begin
               cur_status_in = sb;
               if (sb < ST_SYSEX) begin
                  prefix_in  = 8'd0;
                  running_in = sb;
                  total_in   = (sb[7:4] == 4'hC || sb[7:4] == 4'hD) ?
                               VAL_W'(1) : VAL_W'(2);
                  remain_in  = total_in;
                  cap_idx_in = '0;
                  phase_in   = PH_DATA;
                  cap_en     = !req_data_byte[7];
               end else if (sb == ST_SYSEX || sb == ST_SYSCONT) begin
                  running_in = 8'd0;
                  phase_in   = PH_LEN;
                  vlq_cnt_in = '0;
                  remain_in  = '0;
               end else if (sb == ST_META) begin
                  running_in = 8'd0;
                  phase_in   = PH_MTYPE;
               end else begin
                  err = 1'b1;
               end
            end
         end
         PH_DATA, PH_PAYLOAD: begin
            cap_en = 1'b1;
         end
         PH_MTYPE: begin
            meta_in    = req_data_byte;
            phase_in   = PH_LEN;
            vlq_cnt_in = '0;
            remain_in  = '0;
         end
         PH_LEN: begin
            remain_in = vlq_len;
            if (!req_data_byte[7]) begin
               vlq_cnt_in = '0;
               total_in   = vlq_len;
               cap_idx_in = '0;
               if (vlq_len == '0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               vlq_cnt_in = vlq_inc;
               if (vlq_inc >= VLQ_CNT_W'(MAX_VLQ_BYTES)) begin
                  err = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // store one payload byte while capture room is left, and count it off
      if (cap_en) begin
         if (cap_idx_in < CAP_IDX_W'(CAPTURE_BYTES)) begin
            cap_in[cap_idx_in[CAP_SEL_W-1:0]] = req_data_byte;
            cap_idx_in = cap_idx_in + CAP_IDX_W'(1);
         end
         remain_in = remain_in - VAL_W'(1);
         if (remain_in == '0) begin
            done = 1'b1;
         end
      end

      // event fields; a channel event takes its channel from the status, others the prefix held before this event
      if (cur_status_in < ST_SYSEX) begin
         kind      = KIND_CHANNEL;
         ev_status = cur_status_in;
         ev_chan   = {4'd0, cur_status_in[3:0]};
      end else begin
         ev_chan = prefix_ff;
         if (cur_status_in == ST_SYSEX) begin
            kind      = KIND_SYSEX;
            ev_status = ST_SYSEX;
         end else if (cur_status_in == ST_SYSCONT) begin
            kind      = KIND_SYSCONT;
            ev_status = ST_SYSCONT;
         end else begin
            kind      = KIND_META;
            ev_status = meta_in;
         end
      end

      // meta side effects
      if (!err && done && kind == KIND_META) begin
         case (meta_in)
            META_CHAN_PFX: begin
               if (total_in != '0) begin
                  prefix_in = cap_in[0];
               end
            end
            META_EOT: begin
               eot = 1'b1;
            end
            META_TEMPO: begin
               if (total_in == VAL_W'(3)) begin
                  tempo_in = {cap_in[0], cap_in[1], cap_in[2]};
               end
            end
            META_TIMESIG: begin
               if (total_in == VAL_W'(4)) begin
                  num_in    = cap_in[0];
                  denexp_in = cap_in[1];
                  clocks_in = cap_in[2];
                  t32_in    = cap_in[3];
               end
            end
            default: begin
            end
         endcase
      end

      // end words carry only the timing
      end_word.tempo_usec          = tempo_in;
      end_word.ts_numerator        = num_in;
      end_word.sig_denominator_exp = denexp_in;
      end_word.sig_clock_info      = {clocks_in, t32_in};

      if (err) begin
         word0         = end_word;
         word0.outcome = OUTCOME_ERROR;
         push_n        = 2'd1;
         phase_in      = PH_SKIP;
      end else if (done) begin
         word0                = end_word;
         word0.outcome        = OUTCOME_EVENT;
         word0.event_kind     = kind;
         word0.delta_ticks    = delta_in;
         word0.status_value   = ev_status;
         word0.channel_number = ev_chan;
         word0.data_first     = (total_in > VAL_W'(0)) ? cap_in[0] : 8'd0;
         word0.data_second    = (total_in > VAL_W'(1)) ? cap_in[1] : 8'd0;
         word0.payload_length = total_in;
         push_n               = 2'd1;
         delta_in             = '0;
         vlq_cnt_in           = '0;
         phase_in             = PH_DELTA;
         if (eot || req_chunk_end) begin
            word1         = end_word;
            word1.outcome = OUTCOME_END;
            push_n        = 2'd2;
            phase_in      = PH_SKIP;
         end
      end else if (req_chunk_end && phase_in != PH_SKIP) begin
         // chunk ran out inside an event
         word0         = end_word;
         word0.outcome = OUTCOME_ERROR;
         push_n        = 2'd1;
      end

      // chunk end starts a fresh track, timing stays
      if (req_chunk_end) begin
         phase_in      = PH_DELTA;
         delta_in      = '0;
         vlq_cnt_in    = '0;
         running_in    = 8'd0;
         prefix_in     = 8'd0;
         cur_status_in = 8'd0;
         meta_in       = 8'd0;
         remain_in     = '0;
         total_in      = '0;
         cap_idx_in    = '0;
         for (int i = 0; i < CAPTURE_BYTES; i++) begin
            cap_in[i] = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DELTA;
         delta_ff      <= '0;
         vlq_cnt_ff    <= '0;
         running_ff    <= 8'd0;
         prefix_ff     <= 8'd0;
         cur_status_ff <= 8'd0;
         meta_ff       <= 8'd0;
         remain_ff     <= '0;
         total_ff      <= '0;
         cap_idx_ff    <= '0;
         for (int i = 0; i < CAPTURE_BYTES; i++) begin
            cap_ff[i] <= 8'd0;
         end
         tempo_ff      <= TEMPO_RESET;
         num_ff        <= NUM_RESET;
         denexp_ff     <= DENEXP_RESET;
         clocks_ff     <= CLOCKS_RESET;
         t32_ff        <= T32_RESET;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         delta_ff      <= delta_in;
         vlq_cnt_ff    <= vlq_cnt_in;
         running_ff    <= running_in;
         prefix_ff     <= prefix_in;
         cur_status_ff <= cur_status_in;
         meta_ff       <= meta_in;
         remain_ff     <= remain_in;
         total_ff      <= total_in;
         cap_idx_ff    <= cap_idx_in;
         cap_ff        <= cap_in;
         tempo_ff      <= tempo_in;
         num_ff        <= num_in;
         denexp_ff     <= denexp_in;
         clocks_ff     <= clocks_in;
         t32_ff        <= t32_in;
      end
   end

   // result queue
   always_comb begin
      rsp_cnt_in = rsp_cnt_ff - RSP_CNT_W'(rsp_pop);
      if (req_accept) begin
         rsp_cnt_in = rsp_cnt_in + RSP_CNT_W'(push_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         rsp_cnt_ff <= rsp_cnt_in;
         if (req_accept) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(push_n);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && push_n != 2'd0) begin
         rsp_q_ff[wr_ptr_ff] <= word0;
      end
      if (req_accept && push_n == 2'd2) begin
         rsp_q_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= word1;
      end
   end

   assign rsp_valid               = (rsp_cnt_ff != '0);
   assign rsp_outcome             = rsp_q_ff[rd_ptr_ff].outcome;
   assign rsp_event_kind          = rsp_q_ff[rd_ptr_ff].event_kind;
   assign rsp_delta_ticks         = rsp_q_ff[rd_ptr_ff].delta_ticks;
   assign rsp_status_value        = rsp_q_ff[rd_ptr_ff].status_value;
   assign rsp_channel_number      = rsp_q_ff[rd_ptr_ff].channel_number;
   assign rsp_data_first          = rsp_q_ff[rd_ptr_ff].data_first;
   assign rsp_data_second         = rsp_q_ff[rd_ptr_ff].data_second;
   assign rsp_payload_length      = rsp_q_ff[rd_ptr_ff].payload_length;
   assign rsp_tempo_usec          = rsp_q_ff[rd_ptr_ff].tempo_usec;
   assign rsp_ts_numerator        = rsp_q_ff[rd_ptr_ff].ts_numerator;
   assign rsp_sig_denominator_exp = rsp_q_ff[rd_ptr_ff].sig_denominator_exp;
   assign rsp_sig_clock_info      = rsp_q_ff[rd_ptr_ff].sig_clock_info;

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // an overlong vlq leaves the count at its limit until the chunk ends
   a_vlq_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SKIP |-> vlq_cnt_ff < VLQ_CNT_W'(MAX_VLQ_BYTES))
      else $error("vlq byte count past limit");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_PAYLOAD) |-> remain_ff != '0)
      else $error("payload phase with nothing left");

   a_chunk_end_fresh: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chunk_end |=>
         phase_ff == PH_DELTA && running_ff == 8'd0 && prefix_ff == 8'd0)
      else $error("chunk end did not start a fresh track");

   a_error_skips: assert property (@(posedge clock) disable iff (reset)
      req_accept && err && !req_chunk_end |=> phase_ff == PH_SKIP)
      else $error("error did not enter skip");

endmodule
`default_nettype wire
